/* rtl/ptmw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmw_pkg
// shared types and constants of the palindromic tree scorer
// ----------------------------------------------------------------------------
package ptmw_pkg;

    localparam int CHAR_W     = 5;
    localparam int BEST_W     = 25;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    localparam int EVEN_ROOT  = 1;
    localparam int ODD_ROOT   = 2;
    localparam int FIRST_REAL = 3;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic walk_pos;
        logic walk_cmp;
        logic take_cur;
        logic use_child;
        logic start_walk2;
        logic take_link;
        logic create;
        logic inc_rd;
        logic inc_wr;
        logic fin_start;
        logic fin_rd;
        logic fin_a;
        logic fin_b;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic append;
        logic pos_found;
        logic pos_skip;
        logic cmp_match;
        logic child_zero;
        logic cur_is_odd;
        logic total_small;
        logic fin_last;
        logic out_free;
    } status_t;

endpackage

/* rtl/palindromic_tree_max_weight_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_tree_max_weight_top
// online palindromic tree over a letter stream, scores best length * count
// ----------------------------------------------------------------------------
// After reset all MAX_LEN+3 times ALPHABET child entries (106574 at the
// defaults) are wiped with s_tready low. Each stored letter then walks
// suffix links (every walk has at least one step); every step reads node
// length and link from memory and, unless it stops at the odd root or
// skips a node too long to extend, then compares with the text memory. A
// beat with tlast set starts the count pass over the nodes created in the
// string, after which one result beat is presented: m_tdata holds the best
// length times occurrence count, m_tuser flags letters dropped for lack of
// room. A new string may start while that result waits to be taken.
module palindromic_tree_max_weight_top #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ptmw_pkg::S_TDATA_W-1:0]    s_tdata,   // [4:0] char_code
    input  logic                              s_tlast,   // end_of_string
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ptmw_pkg::M_TDATA_W-1:0]    m_tdata,   // [24:0] best_value
    output logic [0:0]                        m_tuser    // [0] overflowed
);

    ptmw_pkg::cmd_t    cmd;
    ptmw_pkg::status_t status;
    logic [ptmw_pkg::BEST_W-1:0] best;
    logic                        ovf;

    ptmw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ptmw_datapath #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_char   (s_tdata[ptmw_pkg::CHAR_W-1:0]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_best   (best),
        .m_ovf    (ovf)
    );

    assign m_tdata = ptmw_pkg::M_TDATA_W'(best);
    assign m_tuser = ovf;

endmodule

/* rtl/ptmw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmw_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ptmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ptmw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmw_ctrl
// sequencer for letter insertion, suffix link walks and the final count pass
// ----------------------------------------------------------------------------
module ptmw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  ptmw_pkg::status_t status,
    output ptmw_pkg::cmd_t    cmd
);

    typedef enum logic [15:0] {
        CLEAR   = 16'h0001,
        IDLE    = 16'h0002,
        W_RD    = 16'h0004,
        W_POS   = 16'h0008,
        W_CMP   = 16'h0010,
        C_RD    = 16'h0020,
        C_EVAL  = 16'h0040,
        L_RD    = 16'h0080,
        L_EVAL  = 16'h0100,
        CREATE  = 16'h0200,
        I_RD    = 16'h0400,
        I_WR    = 16'h0800,
        F_INIT  = 16'h1000,
        F_RD    = 16'h2000,
        F_AB    = 16'h4000,
        DONE    = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   walk2_reg, walk2_next;
    logic   last_reg, last_next;
    logic   fin_b_reg, fin_b_next;
    state_t found_state;
    state_t end_state;

    assign s_tready    = (state_reg == IDLE);
    assign found_state = walk2_reg ? L_RD : C_RD;
    assign end_state   = last_reg ? F_INIT : IDLE;

    always_comb begin
        state_next = state_reg;
        walk2_next = walk2_reg;
        last_next  = last_reg;
        fin_b_next = fin_b_reg;
        cmd        = '0;
        unique case (state_reg)
            CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    last_next  = s_tlast;
                    walk2_next = 1'b0;
                    if (status.append) begin
                        state_next = W_RD;
                    end else if (s_tlast) begin
                        state_next = F_INIT;
                    end
                end
            end
            W_RD: state_next = W_POS;
            W_POS: begin
                cmd.walk_pos = 1'b1;
                if (status.pos_found) begin
                    cmd.take_cur = !walk2_reg;
                    state_next   = found_state;
                end else if (status.pos_skip) begin
                    state_next = W_RD;
                end else begin
                    state_next = W_CMP;
                end
            end
            W_CMP: begin
                cmd.walk_cmp = 1'b1;
                if (status.cmp_match) begin
                    cmd.take_cur = !walk2_reg;
                    state_next   = found_state;
                end else begin
                    state_next = W_RD;
                end
            end
            C_RD: state_next = C_EVAL;
            C_EVAL: begin
                if (!status.child_zero) begin
                    cmd.use_child = 1'b1;
                    state_next    = I_RD;
                end else if (status.cur_is_odd) begin
                    // single letter node links to the even root
                    cmd.take_link = 1'b1;
                    state_next    = CREATE;
                end else begin
                    cmd.start_walk2 = 1'b1;
                    walk2_next      = 1'b1;
                    state_next      = W_RD;
                end
            end
            L_RD: state_next = L_EVAL;
            L_EVAL: begin
                cmd.take_link = 1'b1;
                state_next    = CREATE;
            end
            CREATE: begin
                cmd.create = 1'b1;
                state_next = end_state;
            end
            I_RD: begin
                cmd.inc_rd = 1'b1;
                state_next = I_WR;
            end
            I_WR: begin
                cmd.inc_wr = 1'b1;
                state_next = end_state;
            end
            F_INIT: begin
                cmd.fin_start = 1'b1;
                fin_b_next    = 1'b0;
                state_next    = status.total_small ? DONE : F_RD;
            end
            F_RD: begin
                cmd.fin_rd = 1'b1;
                fin_b_next = 1'b0;
                state_next = F_AB;
            end
            F_AB: begin
                // fin_a takes in the node and reads its link's count, fin_b folds its count into its link
                if (!fin_b_reg) begin
                    cmd.fin_a  = 1'b1;
                    fin_b_next = 1'b1;
                end else begin
                    cmd.fin_b  = 1'b1;
                    state_next = status.fin_last ? DONE : F_RD;
                end
            end
            DONE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR;
            walk2_reg <= 1'b0;
            last_reg  <= 1'b0;
            fin_b_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            walk2_reg <= walk2_next;
            last_reg  <= last_next;
            fin_b_reg <= fin_b_next;
        end
    end

endmodule

/* rtl/ptmw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmw_datapath
// text, node and child memories with the walk, insert and scoring registers
// ----------------------------------------------------------------------------
module ptmw_datapath #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ptmw_pkg::cmd_t                cmd,
    output ptmw_pkg::status_t             status,
    input  logic [ptmw_pkg::CHAR_W-1:0]   s_char,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [ptmw_pkg::BEST_W-1:0]   m_best,
    output logic                          m_ovf
);

    localparam int NODE_SLOTS  = MAX_LEN + 3;
    localparam int NW          = $clog2(NODE_SLOTS);
    localparam int TW          = $clog2(MAX_LEN + 1);
    localparam int CHILD_DEPTH = NODE_SLOTS * ALPHABET;
    localparam int CAW         = $clog2(CHILD_DEPTH);
    localparam int PW          = 2 * TW;
    localparam int CHW         = ptmw_pkg::CHAR_W;

    localparam logic [NW-1:0] EVEN  = NW'(ptmw_pkg::EVEN_ROOT);
    localparam logic [NW-1:0] ODD   = NW'(ptmw_pkg::ODD_ROOT);
    localparam logic [NW-1:0] FIRST = NW'(ptmw_pkg::FIRST_REAL);

    // control registers
    logic [TW-1:0]  tl_reg;
    logic [NW-1:0]  newest_reg;
    logic [NW-1:0]  total_reg;
    logic           ovf_reg;
    logic           out_valid_reg;
    logic [CAW-1:0] cl_reg;

    // payload registers
    logic [CHW-1:0]    letter_reg;
    logic [NW-1:0]     node_reg;
    logic [NW-1:0]     link_reg;
    logic [TW-1:0]     wlen_reg;
    logic [NW-1:0]     cur_reg;
    logic [NW-1:0]     cur_link_reg;
    logic [TW-1:0]     new_len_reg;
    logic [NW-1:0]     newlink_reg;
    logic [NW-1:0]     i_reg;
    logic [NW-1:0]     fin_link_reg;
    logic [TW-1:0]     fin_occ_reg;
    logic [PW-1:0]     prod_reg;
    logic [PW-1:0]     best_reg;
    logic [ptmw_pkg::BEST_W-1:0] out_best_reg;
    logic              out_ovf_reg;

    // memory ports
    logic [CHW-1:0] text_rd;
    logic [TW-1:0]  text_raddr;
    logic [TW-1:0]  len_rd;
    logic [NW-1:0]  link_rd;
    logic [NW-1:0]  node_raddr;
    logic [TW-1:0]  occ_rd;
    logic [NW-1:0]  occ_raddr;
    logic           occ_we;
    logic [NW-1:0]  occ_waddr;
    logic [TW-1:0]  occ_wdata;
    logic [CAW-1:0] slot_rd;
    logic [NW-1:0]  child_rd;
    logic           child_we;
    logic [CAW-1:0] child_waddr;
    logic [NW-1:0]  child_wdata;

    logic [TW-1:0]  len_sel;
    logic [NW-1:0]  link_sel;
    logic [CAW-1:0] node_slot;
    logic [CAW-1:0] cur_slot;
    logic [NW-1:0]  fresh;
    logic           letter_ok;
    logic           room;
    logic           fin_link_real;

    // the even root has length zero and links to the odd root
    assign len_sel   = (node_reg == EVEN) ? '0 : len_rd;
    assign link_sel  = (node_reg == EVEN) ? ODD : link_rd;
    assign node_slot = CAW'(node_reg) * CAW'(ALPHABET) + CAW'(letter_reg);
    assign cur_slot  = CAW'(cur_reg) * CAW'(ALPHABET) + CAW'(letter_reg);
    assign fresh     = total_reg + NW'(1);
    assign letter_ok = int'(s_char) < ALPHABET;
    assign room      = tl_reg < TW'(MAX_LEN);
    assign fin_link_real = fin_link_reg >= FIRST;

    assign text_raddr = tl_reg - len_sel - TW'(1);
    assign node_raddr = cmd.fin_rd ? i_reg : node_reg;

    always_comb begin
        if (cmd.inc_rd) begin
            occ_raddr = newest_reg;
        end else if (cmd.fin_a) begin
            occ_raddr = link_rd;
        end else begin
            occ_raddr = i_reg;
        end
    end

    always_comb begin
        occ_we    = cmd.create | cmd.inc_wr | (cmd.fin_b & fin_link_real);
        occ_waddr = fin_link_reg;
        occ_wdata = occ_rd + fin_occ_reg;
        if (cmd.create) begin
            occ_waddr = fresh;
            occ_wdata = TW'(1);
        end else if (cmd.inc_wr) begin
            occ_waddr = newest_reg;
            occ_wdata = occ_rd + TW'(1);
        end
    end

    always_comb begin
        child_we    = cmd.clr_step | cmd.create | cmd.fin_a;
        child_wdata = '0;
        child_waddr = slot_rd;
        if (cmd.clr_step) begin
            child_waddr = cl_reg;
        end else if (cmd.create) begin
            child_waddr = cur_slot;
            child_wdata = fresh;
        end
    end

    ptmw_ram #(.WIDTH(CHW), .DEPTH(MAX_LEN + 1)) u_text (
        .aclk  (aclk),
        .we    (cmd.accept & letter_ok & room),
        .waddr (tl_reg + TW'(1)),
        .wdata (s_char),
        .raddr (text_raddr),
        .rdata (text_rd)
    );

    ptmw_ram #(.WIDTH(TW), .DEPTH(NODE_SLOTS)) u_len (
        .aclk  (aclk),
        .we    (cmd.create),
        .waddr (fresh),
        .wdata (new_len_reg),
        .raddr (node_raddr),
        .rdata (len_rd)
    );

    ptmw_ram #(.WIDTH(NW), .DEPTH(NODE_SLOTS)) u_link (
        .aclk  (aclk),
        .we    (cmd.create),
        .waddr (fresh),
        .wdata (newlink_reg),
        .raddr (node_raddr),
        .rdata (link_rd)
    );

    ptmw_ram #(.WIDTH(TW), .DEPTH(NODE_SLOTS)) u_occ (
        .aclk  (aclk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .raddr (occ_raddr),
        .rdata (occ_rd)
    );

    // child entry each node was hung on, used to wipe it after the string
    ptmw_ram #(.WIDTH(CAW), .DEPTH(NODE_SLOTS)) u_slot (
        .aclk  (aclk),
        .we    (cmd.create),
        .waddr (fresh),
        .wdata (cur_slot),
        .raddr (i_reg),
        .rdata (slot_rd)
    );

    ptmw_ram #(.WIDTH(NW), .DEPTH(CHILD_DEPTH)) u_child (
        .aclk  (aclk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .raddr (node_slot),
        .rdata (child_rd)
    );

    assign status.clr_last    = (cl_reg == CAW'(CHILD_DEPTH - 1));
    assign status.append      = letter_ok & room;
    assign status.pos_found   = (node_reg == ODD);
    assign status.pos_skip    = (node_reg != ODD) &&
                                ((TW + 1)'(len_sel) + (TW + 1)'(2) > (TW + 1)'(tl_reg));
    assign status.cmp_match   = (text_rd == letter_reg);
    assign status.child_zero  = (child_rd == '0);
    assign status.cur_is_odd  = (cur_reg == ODD);
    assign status.total_small = (total_reg < FIRST);
    assign status.fin_last    = (i_reg == FIRST);
    assign status.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_best   = out_best_reg;
    assign m_ovf    = out_ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tl_reg        <= '0;
            newest_reg    <= EVEN;
            total_reg     <= ODD;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            cl_reg        <= '0;
        end else begin
            if (cmd.clr_step) begin
                cl_reg <= cl_reg + CAW'(1);
            end
            if (cmd.accept) begin
                if (letter_ok && room) begin
                    tl_reg     <= tl_reg + TW'(1);
                    newest_reg <= newest_reg;
                end else if (letter_ok) begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.use_child) begin
                newest_reg <= child_rd;
            end
            if (cmd.create) begin
                total_reg  <= fresh;
                newest_reg <= fresh;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                tl_reg        <= '0;
                newest_reg    <= EVEN;
                total_reg     <= ODD;
                ovf_reg       <= 1'b0;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            letter_reg <= s_char;
            node_reg   <= newest_reg;
        end
        if (cmd.walk_pos) begin
            wlen_reg <= len_sel;
            link_reg <= link_sel;
            if (status.pos_skip) begin
                node_reg <= link_sel;
            end
        end
        if (cmd.walk_cmp && !status.cmp_match) begin
            node_reg <= link_reg;
        end
        if (cmd.take_cur) begin
            cur_reg      <= node_reg;
            cur_link_reg <= link_reg;
            new_len_reg  <= (node_reg == ODD) ? TW'(1) : wlen_reg + TW'(2);
        end
        if (cmd.start_walk2) begin
            node_reg <= cur_link_reg;
        end
        if (cmd.take_link) begin
            newlink_reg <= status.child_zero ? EVEN : child_rd;
        end
        if (cmd.fin_start) begin
            i_reg    <= total_reg;
            best_reg <= '0;
        end
        if (cmd.fin_a) begin
            fin_link_reg <= link_rd;
            fin_occ_reg  <= occ_rd;
            prod_reg     <= PW'(len_rd) * PW'(occ_rd);
        end
        if (cmd.fin_b) begin
            if (prod_reg > best_reg) begin
                best_reg <= prod_reg;
            end
            i_reg <= i_reg - NW'(1);
        end
        if (cmd.emit) begin
            out_best_reg <= ptmw_pkg::BEST_W'(best_reg);
            out_ovf_reg  <= ovf_reg;
        end
    end

endmodule

/* sim/tb_palindromic_tree_max_weight_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palindromic_tree_max_weight_top
// self-checking bench for the palindromic tree scorer
// ----------------------------------------------------------------------------
// Strings of letter codes are streamed in with random gaps. A local eertree
// computes the best length * count score and the drop flag for every string.
// Each result beat is checked against the oldest predicted score. Runs cover
// empty strings, ignored codes, capacity overflow, a long receiver hold-off
// and random strings over narrow and full alphabets.
// ----------------------------------------------------------------------------
module tb_palindromic_tree_max_weight_top;

    localparam int MAX_LEN  = 4096;
    localparam int ALPHABET = 26;
    localparam int NODES    = MAX_LEN + 3;
    localparam int LIMIT    = 3000000;

    typedef struct packed {
        logic [ptmw_pkg::BEST_W-1:0] best;
        logic                        ovf;
    } score_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ptmw_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ptmw_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [0:0]                      m_tuser;

    palindromic_tree_max_weight_top #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // local eertree
    logic [4:0] txt [0:MAX_LEN];
    int         kid [0:NODES-1][0:ALPHABET-1];
    int         plen [0:NODES-1];
    int         plink [0:NODES-1];
    int         pcnt [0:NODES-1];
    int         tlen, newest, ntotal;
    bit         dropped;

    score_t     score_q[$];
    int         errors = 0;
    int         cycles = 0;
    bit         idle_on = 1'b1;
    bit         hold_req = 1'b0;
    bit         hold_active = 1'b0;

    task automatic tree_clear(input int used);
        for (int i = 0; i <= used && i < NODES; i++) begin
            for (int a = 0; a < ALPHABET; a++) kid[i][a] = 0;
            plen[i] = 0;
            plink[i] = 0;
            pcnt[i] = 0;
        end
        plen[ptmw_pkg::ODD_ROOT] = -1;
        plink[ptmw_pkg::EVEN_ROOT] = ptmw_pkg::ODD_ROOT;
        plink[ptmw_pkg::ODD_ROOT] = ptmw_pkg::ODD_ROOT;
        tlen = 0;
        newest = ptmw_pkg::EVEN_ROOT;
        ntotal = 2;
        dropped = 1'b0;
    endtask

    function automatic int extendable(input int node);
        int pos;
        forever begin
            pos = tlen - plen[node] - 1;
            if (pos >= 1 && txt[pos] == txt[tlen]) return node;
            if (node == ptmw_pkg::ODD_ROOT) return node;
            node = plink[node];
        end
    endfunction

    task automatic tree_step(input logic [4:0] c, input logic last);
        int cur, fresh, lnk;
        longint best, v;
        score_t s;
        if (c < ALPHABET) begin
            if (tlen < MAX_LEN) begin
                tlen++;
                txt[tlen] = c;
                cur = extendable(newest);
                if (kid[cur][c] == 0) begin
                    ntotal++;
                    fresh = ntotal;
                    plen[fresh] = plen[cur] + 2;
                    lnk = (cur == ptmw_pkg::ODD_ROOT) ? 0 : kid[extendable(plink[cur])][c];
                    plink[fresh] = lnk != 0 ? lnk : ptmw_pkg::EVEN_ROOT;
                    kid[cur][c] = fresh;
                end
                newest = kid[cur][c];
                pcnt[newest]++;
            end else begin
                dropped = 1'b1;
            end
        end
        if (last) begin
            best = 0;
            for (int i = ntotal; i >= ptmw_pkg::FIRST_REAL; i--)
                pcnt[plink[i]] += pcnt[i];
            for (int i = ptmw_pkg::FIRST_REAL; i <= ntotal; i++) begin
                v = longint'(plen[i]) * pcnt[i];
                if (v > best) best = v;
            end
            s.best = best[ptmw_pkg::BEST_W-1:0];
            s.ovf = dropped;
            score_q.push_back(s);
            tree_clear(ntotal);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one letter beat, accepted at a rising edge with tvalid and tready high
    task automatic send_letter(input logic [4:0] c, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, c};
        s_tlast  <= last;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        tree_step(c, last);
    endtask

    task automatic send_string(input int n, input int span, input int junk_pct);
        logic [4:0] c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < junk_pct) c = 5'($urandom_range(ALPHABET, 31));
            else c = 5'($urandom_range(0, span - 1));
            send_letter(c, i == n - 1);
        end
    endtask

    task automatic test_directed;
        send_letter(5'd0, 1'b1);
        send_letter(5'd31, 1'b1);                 // ignored code, empty string
        send_letter(5'd25, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b1);
        for (int i = 0; i < 4; i++) send_letter(5'd0, i == 3);
        send_letter(5'd0, 1'b0);
        send_letter(5'd1, 1'b0);
        send_letter(5'd26, 1'b0);                 // ignored inside a string
        send_letter(5'd0, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd1, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd30, 1'b1);                 // end mark on an ignored code
    endtask

    task automatic test_overflow;
        for (int i = 0; i < MAX_LEN; i++) send_letter(($urandom_range(0, 15) == 0) ? 5'd1 : 5'd0, 1'b0);
        send_letter(5'd3, 1'b0);
        send_letter(5'd2, 1'b1);                  // dropped letter carries the end mark
    endtask

    task automatic test_backpressure;
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) send_string($urandom_range(1, 5), 3, 0);
    endtask

    task automatic test_random(input int items);
        int n, sent, pick;
        sent = 0;
        while (sent < items) begin
            n = $urandom_range(1, 20);
            pick = $urandom_range(0, 9);
            if (pick < 6) send_string(n, $urandom_range(1, 3), 0);
            else if (pick < 9) send_string(n, ALPHABET, 5);
            else send_string(n, ALPHABET, 60);
            sent += n;
        end
    endtask

    // receiver: random stall bursts, plus the long hold-off
    int stall_left = 0;
    always @(negedge aclk) begin
        if (hold_active) begin
            m_tready <= 1'b0;
        end else if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_active = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_active = 1'b0;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        score_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (score_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = score_q.pop_front();
                if (m_tdata[ptmw_pkg::BEST_W-1:0] !== want.best)
                    report_mismatch("best_value", m_tdata[ptmw_pkg::BEST_W-1:0], want.best);
                if (m_tuser[0] !== want.ovf)
                    report_mismatch("overflowed", m_tuser[0], want.ovf);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        tree_clear(NODES - 1);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed;
        test_overflow;
        test_backpressure;
        test_random(500);
        idle_on = 1'b0;
        test_random(100);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (score_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ptmw_pkg.sv
rtl/ptmw_ram.sv
rtl/ptmw_ctrl.sv
rtl/ptmw_datapath.sv
rtl/palindromic_tree_max_weight_top.sv
sim/tb_palindromic_tree_max_weight_top.sv
